FILE: rtl/day_count_to_calendar_date_macros.svh
// Assertion macros shared by the calendar date RTL.
// Included by dcd_date_pipe and day_count_to_calendar_date; no other dependencies.
// Define NO_ASSERTIONS to compile every check away.
`ifndef DAY_COUNT_TO_CALENDAR_DATE_MACROS_SVH
`define DAY_COUNT_TO_CALENDAR_DATE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check cons in the same cycle as ante.
`define DCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("calendar date check failed");

// Check cons in the cycle after ante.
`define DCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("calendar date check failed");

`else

`define DCD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DCD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/dcd_pkg.sv
// Types and constants for the day count to calendar date block.
// No dependencies; used by dcd_date_pipe and day_count_to_calendar_date.
`timescale 1ns / 1ps
`default_nettype none

package dcd_pkg;

    // Pipeline depth from accepted beat to result strobe
    localparam int PIPE_DEPTH = 6;

    // Day count is shifted so that day 0 is 1600-03-01 (start of a 400-year era)
    localparam logic [17:0] DAY_OFFSET  = 18'd146037;
    localparam logic [17:0] ERA_DAYS    = 18'd146097;
    localparam logic [17:0] CENT1_DAYS  = 18'd36524;
    localparam logic [17:0] CENT2_DAYS  = 18'd73048;
    localparam logic [17:0] CENT3_DAYS  = 18'd109572;

    // Four-year cycle: quotient by reciprocal multiply, exact for values <= 36524
    localparam logic [15:0] QUAD_DAYS   = 16'd1461;
    localparam logic [31:0] QUAD_RECIP  = 32'd45934;
    localparam int          QUAD_SHIFT  = 26;

    localparam logic [10:0] YEAR1_DAYS  = 11'd365;
    localparam logic [10:0] YEAR2_DAYS  = 11'd730;
    localparam logic [10:0] YEAR3_DAYS  = 11'd1095;
    localparam logic [8:0]  CENT_YEARS  = 9'd100;

    localparam logic [11:0] BASE_YEAR   = 12'd1600;
    localparam logic [11:0] ERA_YEARS   = 12'd400;
    localparam logic [11:0] MIN_YEAR    = 12'd2000;
    localparam logic [11:0] MAX_YEAR    = 12'd2179;

    // Months counted from March: index 10 is January, 11 is February
    localparam logic [3:0]  MP_JAN      = 4'd10;
    localparam logic [3:0]  MP_LAST     = 4'd11;
    localparam logic [3:0]  MONTH_MAR   = 4'd3;
    localparam logic [3:0]  MONTH_WRAP  = 4'd9;
    localparam logic [8:0]  MONTH_START [12] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    // Time of day: hour by reciprocal multiply, exact for values < 1440
    localparam logic [15:0] MINUTES_PER_DAY  = 16'd1440;
    localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;
    localparam logic [25:0] MIN_RECIP        = 26'd17477;
    localparam int          MIN_SHIFT        = 20;
    localparam logic [4:0]  SAT_HOUR         = 5'd23;
    localparam logic [5:0]  SAT_MINUTE       = 6'd59;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       oor;
    } t_time;

endpackage

`default_nettype wire

FILE: rtl/dcd_date_pipe.sv
// Six-stage pipeline from day count since 2000-01-01 to year, month, day.
// Depends on dcd_pkg and day_count_to_calendar_date_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "day_count_to_calendar_date_macros.svh"

module dcd_date_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [15:0]   i_days,
    output logic          o_valid,
    output dcd_pkg::t_date o_date
);
    import dcd_pkg::*;

    logic [PIPE_DEPTH-1:0] r_vld;

    logic [17:0] n_z1;
    logic        n_era1;
    logic [17:0] n_doe1;
    logic [17:0] r_doe1;
    logic        r_era1;

    logic [17:0] n_cbase2;
    logic [1:0]  n_c2;
    logic [17:0] n_cdiff2;
    logic [15:0] r_doc2;
    logic [1:0]  r_c2;
    logic        r_era2;

    logic [31:0] n_prod3;
    logic [4:0]  r_q3;
    logic [15:0] r_doc3;
    logic [1:0]  r_c3;
    logic        r_era3;

    logic [15:0] n_qdiff4;
    logic [10:0] r_dq4;
    logic [4:0]  r_q4;
    logic [1:0]  r_c4;
    logic        r_era4;

    logic [1:0]  n_yq5;
    logic [10:0] n_ybase5;
    logic [10:0] n_ydiff5;
    logic [8:0]  n_yoe5;
    logic [8:0]  r_doy5;
    logic [8:0]  r_yoe5;
    logic        r_era5;

    logic [3:0]  n_mp6;
    logic [8:0]  n_mdiff6;
    t_date       n_date6;
    t_date       r_date6;

    // Advance valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // Stage 1: move origin to 1600-03-01, split off the 400-year era
    always_comb begin
        n_z1   = {2'b00, i_days} + DAY_OFFSET;
        n_era1 = (n_z1 >= ERA_DAYS);
        n_doe1 = n_era1 ? (n_z1 - ERA_DAYS) : n_z1;
    end

    // Stage 2: century within the era, capped at 3 for the last leap day
    always_comb begin
        priority if (r_doe1 >= CENT3_DAYS) begin
            n_c2 = 2'd3; n_cbase2 = CENT3_DAYS;
        end else if (r_doe1 >= CENT2_DAYS) begin
            n_c2 = 2'd2; n_cbase2 = CENT2_DAYS;
        end else if (r_doe1 >= CENT1_DAYS) begin
            n_c2 = 2'd1; n_cbase2 = CENT1_DAYS;
        end else begin
            n_c2 = 2'd0; n_cbase2 = '0;
        end
        n_cdiff2 = r_doe1 - n_cbase2;
    end

    // Stage 3: four-year cycle index by reciprocal multiply
    assign n_prod3 = {16'd0, r_doc2} * QUAD_RECIP;

    // Stage 4: day within the four-year cycle
    assign n_qdiff4 = r_doc3 - ({11'd0, r_q3} * QUAD_DAYS);

    // Stage 5: year within the cycle, capped at 3; build year of era
    always_comb begin
        priority if (r_dq4 >= YEAR3_DAYS) begin
            n_yq5 = 2'd3; n_ybase5 = YEAR3_DAYS;
        end else if (r_dq4 >= YEAR2_DAYS) begin
            n_yq5 = 2'd2; n_ybase5 = YEAR2_DAYS;
        end else if (r_dq4 >= YEAR1_DAYS) begin
            n_yq5 = 2'd1; n_ybase5 = YEAR1_DAYS;
        end else begin
            n_yq5 = 2'd0; n_ybase5 = '0;
        end
        n_ydiff5 = r_dq4 - n_ybase5;
        n_yoe5   = ({7'd0, r_c4} * CENT_YEARS) + {2'd0, r_q4, 2'b00} + {7'd0, n_yq5};
    end

    // Stage 6: month from March-based start table, then civil year
    always_comb begin
        n_mp6 = '0;
        for (int k = 1; k <= int'(MP_LAST); k++) begin
            if (r_doy5 >= MONTH_START[k]) begin
                n_mp6 = 4'(k);
            end
        end
        n_mdiff6      = r_doy5 - MONTH_START[n_mp6];
        n_date6.day   = n_mdiff6[4:0] + 5'd1;
        n_date6.month = (n_mp6 < MP_JAN) ? (n_mp6 + MONTH_MAR) : (n_mp6 - MONTH_WRAP);
        n_date6.year  = BASE_YEAR + (r_era5 ? ERA_YEARS : 12'd0) + {3'd0, r_yoe5}
                        + {11'd0, (n_mp6 >= MP_JAN)};
    end

    // Load payload every cycle; valid bits tell which beats are real
    always_ff @(posedge i_clk) begin
        r_doe1  <= n_doe1;
        r_era1  <= n_era1;

        r_doc2  <= n_cdiff2[15:0];
        r_c2    <= n_c2;
        r_era2  <= r_era1;

        r_q3    <= n_prod3[QUAD_SHIFT+4:QUAD_SHIFT];
        r_doc3  <= r_doc2;
        r_c3    <= r_c2;
        r_era3  <= r_era2;

        r_dq4   <= n_qdiff4[10:0];
        r_q4    <= r_q3;
        r_c4    <= r_c3;
        r_era4  <= r_era3;

        r_doy5  <= n_ydiff5[8:0];
        r_yoe5  <= n_yoe5;
        r_era5  <= r_era4;

        r_date6 <= n_date6;
    end

    assign o_valid = r_vld[PIPE_DEPTH-1];
    assign o_date  = r_date6;

    `DCD_ASSERT_IMP(a_month_range, i_clk, i_rst_n, o_valid, (o_date.month >= 4'd1) && (o_date.month <= 4'd12))
    `DCD_ASSERT_IMP(a_day_range, i_clk, i_rst_n, o_valid, (o_date.day >= 5'd1) && (o_date.day <= 5'd31))
    `DCD_ASSERT_IMP(a_year_range, i_clk, i_rst_n, o_valid, (o_date.year >= MIN_YEAR) && (o_date.year <= MAX_YEAR))

endmodule

`default_nettype wire

FILE: rtl/day_count_to_calendar_date.sv
// Top level: day count and minutes of day to calendar date and time of day.
// Depends on dcd_pkg, dcd_date_pipe and day_count_to_calendar_date_macros.svh.
//
// Usage:
//   Drive i_days_since_2000 and i_minutes_of_day and raise start. The beat is
//   taken at a rising edge where start is high and busy is low. busy is high
//   while reset is held and until the first clock edge after its release, and
//   low from then on, so a new beat can be taken at every clock.
//   Each beat gives one result: o_done is high for exactly one cycle with
//   o_year, o_month, o_day_of_month, o_hour, o_minute, o_time_out_of_range.
//   Results come from the six-register date pipeline (era, century,
//   four-year multiply, cycle remainder, year, month); throughput is one beat
//   per cycle. The time path runs beside it and is delayed to match.
//   Minutes of 1440 or more set o_time_out_of_range and give 23:59.
//   Reset (i_rst_n low, synchronous) clears all valid bits; beats in flight
//   are dropped. The receiver cannot stall: results must be taken as shown.
`timescale 1ns / 1ps
`default_nettype none
`include "day_count_to_calendar_date_macros.svh"

module day_count_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_days_since_2000,
    input  logic [15:0] i_minutes_of_day,
    output logic        o_done,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic        o_time_out_of_range
);
    import dcd_pkg::*;

    localparam int TIME_DLY = PIPE_DEPTH - 3;

    logic        r_busy;
    logic        accept;

    logic [10:0] r_mins1;
    logic        r_oor1;

    logic [25:0] n_prod2;
    logic [4:0]  r_hour2;
    logic [10:0] r_mins2;
    logic        r_oor2;

    logic [10:0] n_mdiff3;
    t_time       n_time3;
    t_time       r_time3;
    t_time       r_time_dly [TIME_DLY];

    logic        date_valid;
    t_date       date;

    // Hold busy in reset and until the first clock edge after its release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    dcd_date_pipe u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_days  (i_days_since_2000),
        .o_valid (date_valid),
        .o_date  (date)
    );

    // Hour by reciprocal multiply
    assign n_prod2 = {15'd0, r_mins1} * MIN_RECIP;

    // Minute remainder, then saturate out-of-range time
    always_comb begin
        n_mdiff3 = r_mins2 - ({6'd0, r_hour2} * MINUTES_PER_HOUR);
        if (r_oor2) begin
            n_time3.hour   = SAT_HOUR;
            n_time3.minute = SAT_MINUTE;
        end else begin
            n_time3.hour   = r_hour2;
            n_time3.minute = n_mdiff3[5:0];
        end
        n_time3.oor = r_oor2;
    end

    // Time path payload, delayed to line up with the date pipeline
    always_ff @(posedge i_clk) begin
        r_mins1 <= i_minutes_of_day[10:0];
        r_oor1  <= (i_minutes_of_day >= MINUTES_PER_DAY);

        r_hour2 <= n_prod2[MIN_SHIFT+4:MIN_SHIFT];
        r_mins2 <= r_mins1;
        r_oor2  <= r_oor1;

        r_time3 <= n_time3;

        r_time_dly[0] <= r_time3;
        for (int i = 1; i < TIME_DLY; i++) begin
            r_time_dly[i] <= r_time_dly[i-1];
        end
    end

    assign o_done              = date_valid;
    assign o_year              = date.year;
    assign o_month             = date.month;
    assign o_day_of_month      = date.day;
    assign o_hour              = r_time_dly[TIME_DLY-1].hour;
    assign o_minute            = r_time_dly[TIME_DLY-1].minute;
    assign o_time_out_of_range = r_time_dly[TIME_DLY-1].oor;

    `DCD_ASSERT_IMP(a_latency, i_clk, i_rst_n, accept, ##(PIPE_DEPTH) o_done)
    `DCD_ASSERT_IMP(a_sat_time, i_clk, i_rst_n, o_done && o_time_out_of_range, (o_hour == SAT_HOUR) && (o_minute == SAT_MINUTE))
    `DCD_ASSERT_IMP(a_time_range, i_clk, i_rst_n, o_done, (o_hour <= SAT_HOUR) && (o_minute <= SAT_MINUTE))

endmodule

`default_nettype wire
